FILE: rtl/core/imu_tilt_tracker_macros.svh
// Assertion macros used by the checker file of the tilt tracker.
`ifndef IMU_TILT_TRACKER_MACROS_SVH
`define IMU_TILT_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITT_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITT_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ITT_ASSERT_ALWAYS(lbl, clk, a, c, msg) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

FILE: rtl/core/itt_pkg.sv
// Types and constants shared by the tilt tracker modules.
`default_nettype none
package itt_pkg;

    localparam int SQRT_STEPS = 24;
    localparam int TABLE_LEN  = 24;

    // atan(2^-i) in 1/65536 degree.
    localparam logic [22:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
        23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
    };

    localparam logic [1:0] REG_ROLL_OFFSET    = 2'd0;
    localparam logic [1:0] REG_PITCH_OFFSET   = 2'd1;
    localparam logic [1:0] REG_SNAP_THRESHOLD = 2'd2;

    localparam logic [15:0] SNAP_THRESHOLD_RESET = 16'd1280;

    typedef enum logic [2:0] {
        MUL_ROLL  = 3'd0,
        MUL_PITCH = 3'd1,
        MUL_YAW   = 3'd2,
        MUL_AX    = 3'd3,
        MUL_AZ    = 3'd4,
        MUL_AY    = 3'd5,
        MUL_FLUSH = 3'd6
    } t_mul_op;

    typedef struct packed {
        logic       accept;
        logic       mul_en;
        t_mul_op    mul_op;
        logic       sqrt_load;
        logic       sqrt_step;
        logic       cordic_load;
        logic       cordic_step;
        logic [4:0] step;
        logic       pass;
        logic       snap;
        logic       out_load;
    } t_cmd;

endpackage
`default_nettype wire

FILE: rtl/core/itt_dpath.sv
// Datapath of the tilt tracker: multiplier, square root, CORDIC and angle state.
`default_nettype none
module itt_dpath #(
    parameter int ANGLE_BITS = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire itt_pkg::t_cmd i_cmd,
    input  wire logic [111:0]  i_in_data,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_wdata,
    output logic [71:0]        o_out_data
);

    localparam int WIDE = 40;
    localparam logic signed [WIDE-1:0] ANG_HI = (WIDE'(1) <<< (ANGLE_BITS - 1)) - WIDE'(1);
    localparam logic signed [WIDE-1:0] ANG_LO = -ANG_HI - WIDE'(1);
    localparam logic [47:0] SQRT_BIT0 = 48'h1 << 46;

    logic signed [15:0] r_ax, r_ay, r_az, r_rx, r_ry, r_rz;
    logic [15:0] r_dt;
    logic signed [15:0] r_roll_off, r_pitch_off;
    logic [15:0] r_thr;
    logic signed [ANGLE_BITS-1:0] r_roll, r_pitch, r_yaw;
    logic signed [33:0] r_prod;
    itt_pkg::t_mul_op r_prod_op;
    logic r_prod_vld;
    logic [30:0] r_sq_x, r_sq_y, r_sq_z;
    logic [47:0] r_sv, r_sr, r_sb;
    logic signed [27:0] r_x, r_y;
    logic signed [24:0] r_z;
    logic r_num_zero;
    logic [71:0] r_out;

    logic signed [16:0] mul_a, mul_b;
    logic signed [34:0] rnd_sum;
    logic signed [WIDE-1:0] inc;
    logic [31:0] sq_sum;
    logic [47:0] sq_try;
    logic signed [16:0] num;
    logic signed [27:0] dx, dy;
    logic signed [24:0] ang, z_rnd;
    logic signed [16:0] tilt;
    logic signed [WIDE-1:0] acc, cur, diff, adiff;
    logic signed [WIDE-1:0] r_roll_w, r_pitch_w, r_yaw_w;

    function automatic logic signed [ANGLE_BITS-1:0] sat(input logic signed [WIDE-1:0] v);
        logic signed [WIDE-1:0] t;
        t = v;
        if (v > ANG_HI) begin
            t = ANG_HI;
        end else if (v < ANG_LO) begin
            t = ANG_LO;
        end
        return t[ANGLE_BITS-1:0];
    endfunction

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul_op)
            itt_pkg::MUL_ROLL:  begin mul_a = 17'(r_rx); mul_b = $signed({1'b0, r_dt}); end
            itt_pkg::MUL_PITCH: begin mul_a = 17'(r_ry); mul_b = $signed({1'b0, r_dt}); end
            itt_pkg::MUL_YAW:   begin mul_a = 17'(r_rz); mul_b = $signed({1'b0, r_dt}); end
            itt_pkg::MUL_AX:    begin mul_a = 17'(r_ax); mul_b = 17'(r_ax); end
            itt_pkg::MUL_AZ:    begin mul_a = 17'(r_az); mul_b = 17'(r_az); end
            itt_pkg::MUL_AY:    begin mul_a = 17'(r_ay); mul_b = 17'(r_ay); end
            default:            begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign rnd_sum = 35'(r_prod) + 35'sd16384;
    assign inc     = WIDE'(rnd_sum >>> 15);
    assign sq_sum  = i_cmd.pass ? ({1'b0, r_sq_y} + {1'b0, r_sq_z})
                                : ({1'b0, r_sq_x} + {1'b0, r_sq_z});
    assign sq_try  = r_sr + r_sb;
    assign num     = i_cmd.pass ? -17'(r_ax) : 17'(r_ay);
    assign dx      = r_y >>> i_cmd.step;
    assign dy      = r_x >>> i_cmd.step;
    assign ang     = $signed({2'b00, itt_pkg::ATAN_TABLE[i_cmd.step]});
    assign z_rnd   = r_z + 25'sd128;
    assign tilt    = r_num_zero ? 17'sd0 : z_rnd[24:8];
    assign acc     = WIDE'(tilt) - (i_cmd.pass ? WIDE'(r_pitch_off) : WIDE'(r_roll_off));
    assign cur     = i_cmd.pass ? WIDE'(r_pitch) : WIDE'(r_roll);
    assign diff    = acc - cur;
    assign adiff   = diff[WIDE-1] ? -diff : diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_off  <= '0;
            r_pitch_off <= '0;
            r_thr       <= itt_pkg::SNAP_THRESHOLD_RESET;
            r_roll      <= '0;
            r_pitch     <= '0;
            r_yaw       <= '0;
            r_prod_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    itt_pkg::REG_ROLL_OFFSET:    r_roll_off  <= i_cfg_wdata;
                    itt_pkg::REG_PITCH_OFFSET:   r_pitch_off <= i_cfg_wdata;
                    itt_pkg::REG_SNAP_THRESHOLD: r_thr       <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_prod_vld <= i_cmd.mul_en && (i_cmd.mul_op != itt_pkg::MUL_FLUSH);
            if (r_prod_vld) begin
                unique case (r_prod_op)
                    itt_pkg::MUL_ROLL:  r_roll  <= sat(WIDE'(r_roll) + inc);
                    itt_pkg::MUL_PITCH: r_pitch <= sat(WIDE'(r_pitch) + inc);
                    itt_pkg::MUL_YAW:   r_yaw   <= sat(WIDE'(r_yaw) + inc);
                    default: ;
                endcase
            end
            if (i_cmd.snap && (adiff > WIDE'({1'b0, r_thr}))) begin
                if (i_cmd.pass) begin
                    r_pitch <= sat(acc);
                end else begin
                    r_roll <= sat(acc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ax <= i_in_data[15:0];
            r_ay <= i_in_data[31:16];
            r_az <= i_in_data[47:32];
            r_rx <= i_in_data[63:48];
            r_ry <= i_in_data[79:64];
            r_rz <= i_in_data[95:80];
            r_dt <= i_in_data[111:96];
        end
        r_prod    <= mul_a * mul_b;
        r_prod_op <= i_cmd.mul_op;
        if (r_prod_vld) begin
            unique case (r_prod_op)
                itt_pkg::MUL_AX: r_sq_x <= r_prod[30:0];
                itt_pkg::MUL_AZ: r_sq_z <= r_prod[30:0];
                itt_pkg::MUL_AY: r_sq_y <= r_prod[30:0];
                default: ;
            endcase
        end
        if (i_cmd.sqrt_load) begin
            r_sv <= {sq_sum, 16'h0000};
            r_sr <= '0;
            r_sb <= SQRT_BIT0;
        end else if (i_cmd.sqrt_step) begin
            if (r_sv >= sq_try) begin
                r_sv <= r_sv - sq_try;
                r_sr <= (r_sr >> 1) + r_sb;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_sb <= r_sb >> 2;
        end
        if (i_cmd.cordic_load) begin
            r_x        <= $signed({4'b0000, r_sr[23:0]});
            r_y        <= $signed({{3{num[16]}}, num, 8'h00});
            r_z        <= '0;
            r_num_zero <= (num == 17'sd0);
        end else if (i_cmd.cordic_step) begin
            if (r_y > 28'sd0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + ang;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - ang;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= {r_yaw_w[23:0], r_pitch_w[23:0], r_roll_w[23:0]};
        end
    end

    assign r_roll_w  = WIDE'(r_roll);
    assign r_pitch_w = WIDE'(r_pitch);
    assign r_yaw_w   = WIDE'(r_yaw);

    assign o_out_data = r_out;

endmodule
`default_nettype wire

FILE: rtl/core/itt_ctrl.sv
// Controller state machine of the tilt tracker.
`default_nettype none
module itt_ctrl #(
    parameter int ATAN_ITERATIONS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output itt_pkg::t_cmd o_cmd
);

    localparam int CORDIC_STEPS = (ATAN_ITERATIONS < itt_pkg::TABLE_LEN) ?
                                  ATAN_ITERATIONS : itt_pkg::TABLE_LEN;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_SQ_LD = 8'b0000_0100,
        S_SQ    = 8'b0000_1000,
        S_CD_LD = 8'b0001_0000,
        S_CD    = 8'b0010_0000,
        S_SNAP  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic r_pass, n_pass;
    logic r_out_vld, n_out_vld;

    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        n_pass           = r_pass;
        n_out_vld        = r_out_vld && !i_out_ready;
        o_cmd            = '0;
        o_cmd.mul_op     = itt_pkg::MUL_FLUSH;
        o_cmd.step       = r_cnt;
        o_cmd.pass       = r_pass;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_cnt        = '0;
                    n_pass       = 1'b0;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = itt_pkg::t_mul_op'(r_cnt[2:0]);
                n_cnt        = r_cnt + 5'd1;
                if (itt_pkg::t_mul_op'(r_cnt[2:0]) == itt_pkg::MUL_FLUSH) begin
                    n_state = S_SQ_LD;
                end
            end
            S_SQ_LD: begin
                o_cmd.sqrt_load = 1'b1;
                n_cnt           = '0;
                n_state         = S_SQ;
            end
            S_SQ: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + 5'd1;
                if (r_cnt == 5'(itt_pkg::SQRT_STEPS - 1)) begin
                    n_state = S_CD_LD;
                end
            end
            S_CD_LD: begin
                o_cmd.cordic_load = 1'b1;
                n_cnt             = '0;
                n_state           = S_CD;
            end
            S_CD: begin
                o_cmd.cordic_step = 1'b1;
                n_cnt             = r_cnt + 5'd1;
                if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                    n_state = S_SNAP;
                end
            end
            S_SNAP: begin
                o_cmd.snap = 1'b1;
                if (r_pass) begin
                    n_state = S_DONE;
                end else begin
                    n_pass  = 1'b1;
                    n_state = S_SQ_LD;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pass    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_pass    <= n_pass;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule
`default_nettype wire

FILE: rtl/core/imu_tilt_tracker.sv
// Top level of the IMU tilt tracker.
// One input word is taken when the block is idle; the next word is accepted
// only once its result word has been loaded into the output register, which
// waits while an unread result is still held there. The result waits in that
// output register while the next word is processed. The work is done by the
// 24-step bit-serial square root and the one-step-per-cycle CORDIC, both run
// once for roll and once for pitch, behind the passes of the shared multiplier.
`default_nettype none
module imu_tilt_tracker #(
    parameter int ANGLE_BITS      = 24,
    parameter int ATAN_ITERATIONS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_step
    input  wire logic [111:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // roll, pitch, yaw
    output logic [71:0]       o_m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [15:0]  i_cfg_wdata
);

    itt_pkg::t_cmd cmd;

    itt_ctrl #(
        .ATAN_ITERATIONS(ATAN_ITERATIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    itt_dpath #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

FILE: rtl/core/itt_checker.sv
// Port-level assertions for the tilt tracker and their bind.
`default_nettype none
`include "imu_tilt_tracker_macros.svh"
module itt_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [71:0]  o_m_axis_tdata
);

    `ITT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result word dropped while stalled")
    `ITT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata), "result word changed while stalled")
    `ITT_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken again right after a word")
    `ITT_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n, !o_m_axis_tvalid && o_s_axis_tready, "block not idle after reset")

endmodule

bind imu_tilt_tracker itt_checker u_itt_checker (.*);
`default_nettype wire
